// ----- sv/sccc_pkg.sv -----
// ----------------------------------------------------------------------------
// sccc_pkg
// Shared types and constants of the segment capsule collision check.
// ----------------------------------------------------------------------------
`default_nettype none

package sccc_pkg;

	localparam int RADIUS_WIDTH    = 12;
	localparam int RSQ_WIDTH       = 2 * RADIUS_WIDTH;
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int QUEUE_DEPTH     = 4;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_START_X        = 3'd0,
		REG_START_Y        = 3'd1,
		REG_START_Z        = 3'd2,
		REG_END_X          = 3'd3,
		REG_END_Y          = 3'd4,
		REG_END_Z          = 3'd5,
		REG_SWEEP_RADIUS   = 3'd6,
		REG_END_CELL_KNOWN = 3'd7
	} cfg_reg_t;

	// per-request flags carried through the queue
	typedef struct packed {
		logic test;
		logic last;
	} sccc_tag_t;

	localparam int TAG_WIDTH = $bits(sccc_tag_t);

	// accumulator selected by a multiplier result
	typedef enum logic [2:0] {
		ACC_NONE = 3'd0,
		ACC_SPH  = 3'd1,
		ACC_LSQ  = 3'd2,
		ACC_PP   = 3'd3,
		ACC_DOT  = 3'd4,
		ACC_WL   = 3'd5,
		ACC_WR   = 3'd6
	} acc_dst_t;

endpackage

`default_nettype wire

// ----- sv/sccc_front.sv -----
// ----------------------------------------------------------------------------
// sccc_front
// Accepts cell requests, drops free cells that close no query, tags the rest.
// ----------------------------------------------------------------------------
`default_nettype none

module sccc_front
	import sccc_pkg::*;
#(
	parameter int COORD_WIDTH = 16
) (
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	input  wire logic [3*COORD_WIDTH-1:0] s_cell,
	input  wire logic                     s_occupied,
	input  wire logic                     s_last,
	output logic                          push_valid,
	input  wire logic                     push_ready,
	output logic [3*COORD_WIDTH-1:0]      push_cell,
	output sccc_tag_t                     push_tag
);

	logic keep;

	assign keep       = s_occupied | s_last;
	assign s_tready   = push_ready;
	assign push_valid = s_tvalid & keep;
	assign push_cell  = s_cell;

	always_comb begin
		push_tag.test = s_occupied;
		push_tag.last = s_last;
	end

endmodule

`default_nettype wire

// ----- sv/sccc_queue.sv -----
// ----------------------------------------------------------------------------
// sccc_queue
// Small register FIFO between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module sccc_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [WIDTH-1:0] in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [WIDTH-1:0]      out_data
);

	localparam int PW = $clog2(DEPTH);
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNTW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign in_ready  = (count_q != CNTW'(DEPTH));
	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	assign do_push   = in_valid & in_ready;
	assign do_pop    = out_valid & out_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- sv/sccc_back.sv -----
// ----------------------------------------------------------------------------
// sccc_back
// Configuration registers, shared-multiplier hit test, sticky flag, result.
// ----------------------------------------------------------------------------
`default_nettype none

module sccc_back
	import sccc_pkg::*;
#(
	parameter int COORD_WIDTH = 16,
	parameter int CFG_WIDTH   = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_valid,
	input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  wire logic [CFG_WIDTH-1:0]       cfg_data,
	input  wire logic                       q_valid,
	output logic                            q_ready,
	input  wire logic [3*COORD_WIDTH-1:0]   q_cell,
	input  wire sccc_tag_t                  q_tag,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic                            out_collision
);

	localparam int W  = COORD_WIDTH;
	localparam int H  = W + 1;
	localparam int SW = 2 * H;
	localparam int DW = SW + 1;
	localparam int AW = 4 * H;
	localparam int CW = (SW > RSQ_WIDTH) ? SW : RSQ_WIDTH;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_PREP  = 9'b000000010,
		ST_MULA  = 9'b000000100,
		ST_EVAL  = 9'b000001000,
		ST_CHECK = 9'b000010000,
		ST_MULB  = 9'b000100000,
		ST_FLUSH = 9'b001000000,
		ST_CMP   = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	state_t state_q;

	logic signed [W-1:0]      start_q [3];
	logic signed [W-1:0]      end_q [3];
	logic [RADIUS_WIDTH-1:0]  radius_q;
	logic                     known_q;

	logic signed [W-1:0]      cell_q [3];
	sccc_tag_t                tag_q;
	logic                     hit_q;
	logic                     out_valid_q;
	logic                     out_coll_q;

	logic [1:0]               lane_q;
	logic [1:0]               grp_q;
	logic [2:0]               wstep_q;

	logic [H-1:0]             mec_q [3];
	logic [H-1:0]             md_q [3];
	logic [H-1:0]             mp_q [3];
	logic                     sd_q [3];
	logic                     sp_q [3];
	logic [RSQ_WIDTH-1:0]     rsq_q;

	logic [SW-1:0]            sph_q;
	logic [SW-1:0]            lsq_q;
	logic [SW-1:0]            pp_q;
	logic signed [DW-1:0]     dot_q;
	logic [SW-1:0]            wd_q;
	logic [SW-1:0]            dotm_q;
	logic [AW-1:0]            wl_q;
	logic [AW-1:0]            wr_q;

	logic [SW-1:0]            prod_s1;
	acc_dst_t                 dst_s1;
	logic                     neg_s1;
	logic [1:0]               sh_s1;

	logic signed [W:0]        ec_c [3];
	logic signed [W:0]        d_c [3];
	logic signed [W:0]        p_c [3];

	logic [H-1:0]             mul_a;
	logic [H-1:0]             mul_b;
	acc_dst_t                 iss_dst;
	logic                     iss_neg;
	logic [1:0]               iss_sh;
	logic [SW-1:0]            src_a;
	logic [SW-1:0]            src_b;

	logic [AW-1:0]            prod_wide;
	logic                     sph_hit;
	logic                     in_caps;
	logic                     near_axis;
	logic                     can_emit;
	logic                     emit;

	assign q_ready       = (state_q == ST_IDLE);
	assign out_valid     = out_valid_q;
	assign out_collision = out_coll_q;
	assign can_emit      = !out_valid_q || out_ready;
	assign emit          = (state_q == ST_DONE) && tag_q.last && can_emit;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				start_q[k] <= '0;
				end_q[k]   <= '0;
			end
			radius_q <= RADIUS_WIDTH'(128);
			known_q  <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_START_X:        start_q[0] <= cfg_data[W-1:0];
				REG_START_Y:        start_q[1] <= cfg_data[W-1:0];
				REG_START_Z:        start_q[2] <= cfg_data[W-1:0];
				REG_END_X:          end_q[0]   <= cfg_data[W-1:0];
				REG_END_Y:          end_q[1]   <= cfg_data[W-1:0];
				REG_END_Z:          end_q[2]   <= cfg_data[W-1:0];
				REG_SWEEP_RADIUS:   radius_q   <= cfg_data[RADIUS_WIDTH-1:0];
				REG_END_CELL_KNOWN: known_q    <= cfg_data[0];
				default:            known_q    <= known_q;
			endcase
		end
	end

	// coordinate differences
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ec_c[k] = $signed({end_q[k][W-1], end_q[k]}) -
				$signed({cell_q[k][W-1], cell_q[k]});
			d_c[k]  = $signed({end_q[k][W-1], end_q[k]}) -
				$signed({start_q[k][W-1], start_q[k]});
			p_c[k]  = $signed({cell_q[k][W-1], cell_q[k]}) -
				$signed({start_q[k][W-1], start_q[k]});
		end
	end

	// multiplier operand select
	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		iss_dst = ACC_NONE;
		iss_neg = 1'b0;
		iss_sh  = 2'd0;
		src_a   = wstep_q[2] ? dotm_q : lsq_q;
		src_b   = wstep_q[2] ? dotm_q : wd_q;
		if (state_q == ST_MULA) begin
			case (grp_q)
				2'd0: begin
					mul_a   = mec_q[lane_q];
					mul_b   = mec_q[lane_q];
					iss_dst = ACC_SPH;
				end
				2'd1: begin
					mul_a   = md_q[lane_q];
					mul_b   = md_q[lane_q];
					iss_dst = ACC_LSQ;
				end
				2'd2: begin
					mul_a   = mp_q[lane_q];
					mul_b   = mp_q[lane_q];
					iss_dst = ACC_PP;
				end
				default: begin
					mul_a   = mp_q[lane_q];
					mul_b   = md_q[lane_q];
					iss_dst = ACC_DOT;
					iss_neg = sp_q[lane_q] ^ sd_q[lane_q];
				end
			endcase
		end else if (state_q == ST_MULB) begin
			mul_a   = wstep_q[1] ? src_a[SW-1:H] : src_a[H-1:0];
			mul_b   = wstep_q[0] ? src_b[SW-1:H] : src_b[H-1:0];
			iss_dst = wstep_q[2] ? ACC_WR : ACC_WL;
			iss_sh  = 2'(wstep_q[1]) + 2'(wstep_q[0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_s1 <= ACC_NONE;
		end else begin
			dst_s1 <= iss_dst;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= SW'(mul_a) * SW'(mul_b);
		neg_s1  <= iss_neg;
		sh_s1   <= iss_sh;
	end

	always_comb begin
		case (sh_s1)
			2'd0:    prod_wide = AW'(prod_s1);
			2'd1:    prod_wide = AW'(prod_s1) << H;
			2'd2:    prod_wide = AW'(prod_s1) << (2 * H);
			default: prod_wide = '0;
		endcase
	end

	// decisions after the first pass
	always_comb begin
		sph_hit   = CW'(sph_q) < CW'(rsq_q);
		in_caps   = (lsq_q != '0) && !dot_q[DW-1] && (dot_q[SW-1:0] <= lsq_q);
		near_axis = CW'(pp_q) <= CW'(rsq_q);
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid) begin
			for (int k = 0; k < 3; k++) begin
				cell_q[k] <= q_cell[k*W +: W];
			end
			tag_q <= q_tag;
		end
		if (state_q == ST_PREP) begin
			for (int k = 0; k < 3; k++) begin
				mec_q[k] <= ec_c[k][W] ? unsigned'(-ec_c[k]) : unsigned'(ec_c[k]);
				md_q[k]  <= d_c[k][W] ? unsigned'(-d_c[k]) : unsigned'(d_c[k]);
				mp_q[k]  <= p_c[k][W] ? unsigned'(-p_c[k]) : unsigned'(p_c[k]);
				sd_q[k]  <= d_c[k][W];
				sp_q[k]  <= p_c[k][W];
			end
			rsq_q <= RSQ_WIDTH'(radius_q) * RSQ_WIDTH'(radius_q);
			sph_q <= '0;
			lsq_q <= '0;
			pp_q  <= '0;
			dot_q <= '0;
			wl_q  <= '0;
			wr_q  <= '0;
		end else begin
			case (dst_s1)
				ACC_SPH: sph_q <= sph_q + prod_s1;
				ACC_LSQ: lsq_q <= lsq_q + prod_s1;
				ACC_PP:  pp_q  <= pp_q + prod_s1;
				ACC_DOT: dot_q <= neg_s1 ? dot_q - $signed({1'b0, prod_s1})
					: dot_q + $signed({1'b0, prod_s1});
				ACC_WL:  wl_q  <= wl_q + prod_wide;
				ACC_WR:  wr_q  <= wr_q + prod_wide;
				default: wl_q  <= wl_q;
			endcase
		end
		if (state_q == ST_CHECK) begin
			wd_q   <= SW'(CW'(pp_q) - CW'(rsq_q));
			dotm_q <= dot_q[SW-1:0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_coll_q  <= 1'b0;
			lane_q      <= '0;
			grp_q       <= '0;
			wstep_q     <= '0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= (q_tag.test && !hit_q) ? ST_PREP : ST_DONE;
					end
				end
				ST_PREP: begin
					lane_q  <= '0;
					grp_q   <= '0;
					state_q <= ST_MULA;
				end
				ST_MULA: begin
					if (lane_q == 2'd2) begin
						lane_q <= '0;
						grp_q  <= grp_q + 1'b1;
						if (grp_q == 2'd3) begin
							state_q <= ST_EVAL;
						end
					end else begin
						lane_q <= lane_q + 1'b1;
					end
				end
				ST_EVAL: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					wstep_q <= '0;
					if (sph_hit || (in_caps && near_axis)) begin
						hit_q   <= 1'b1;
						state_q <= ST_DONE;
					end else if (in_caps) begin
						state_q <= ST_MULB;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_MULB: begin
					wstep_q <= wstep_q + 1'b1;
					if (wstep_q == 3'd7) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (wl_q <= wr_q) begin
						hit_q <= 1'b1;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!tag_q.last) begin
						state_q <= ST_IDLE;
					end else if (can_emit) begin
						out_coll_q  <= hit_q | ~known_q;
						hit_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- sv/segment_capsule_collision_check.sv -----
// ----------------------------------------------------------------------------
// segment_capsule_collision_check
// Swept-segment (capsule) hit test over a stream of occupancy cells.
// ----------------------------------------------------------------------------
// channel   dir  handshake                  payload
// s_axis    in   s_axis_tvalid/tready       tdata cell xyz, tuser occupied, tlast
// m_axis    out  m_axis_tvalid/tready       tdata collision
// cfg       in   cfg_valid/cfg_ready        cfg_index, cfg_data
//
// Free cells that close no query pass the front at one per cycle unless the
// queue is full. The back takes one request at a time; a tested cell runs
// through a single shared multiplier, again when the wide cross-multiplied
// cylinder compare runs. Others skip it. A 4-entry queue decouples the two sides.
// Reset clears the control state; config resets to start=end=0, radius 128,
// end cell known. The result sits in an output register while work goes on.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_capsule_collision_check
	import sccc_pkg::*;
#(
	parameter int COORD_WIDTH = 16,
	localparam int IN_TDATA_WIDTH = ((3 * COORD_WIDTH + 7) / 8) * 8,
	localparam int CFG_WIDTH = (COORD_WIDTH > RADIUS_WIDTH) ? COORD_WIDTH : RADIUS_WIDTH
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_axis_tvalid,
	output logic                            s_axis_tready,
	input  wire logic [IN_TDATA_WIDTH-1:0]  s_axis_tdata,  // cell_x, cell_y, cell_z
	input  wire logic                       s_axis_tuser,  // cell_occupied
	input  wire logic                       s_axis_tlast,
	output logic                            m_axis_tvalid,
	input  wire logic                       m_axis_tready,
	output logic [7:0]                      m_axis_tdata,  // collision
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  wire logic [CFG_WIDTH-1:0]       cfg_data
);

	localparam int CELL_W = 3 * COORD_WIDTH;
	localparam int QW = CELL_W + TAG_WIDTH;

	logic              push_valid;
	logic              push_ready;
	logic [CELL_W-1:0] push_cell;
	sccc_tag_t         push_tag;
	logic              q_valid;
	logic              q_ready;
	logic [QW-1:0]     q_data;
	logic              collision;

	assign cfg_ready    = 1'b1;
	assign m_axis_tdata = {7'b0, collision};

	sccc_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.s_tvalid  (s_axis_tvalid),
		.s_tready  (s_axis_tready),
		.s_cell    (s_axis_tdata[CELL_W-1:0]),
		.s_occupied(s_axis_tuser),
		.s_last    (s_axis_tlast),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cell (push_cell),
		.push_tag  (push_tag)
	);

	sccc_queue #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (push_valid),
		.in_ready (push_ready),
		.in_data  ({push_cell, push_tag}),
		.out_valid(q_valid),
		.out_ready(q_ready),
		.out_data (q_data)
	);

	sccc_back #(
		.COORD_WIDTH(COORD_WIDTH),
		.CFG_WIDTH  (CFG_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.q_valid      (q_valid),
		.q_ready      (q_ready),
		.q_cell       (q_data[QW-1:TAG_WIDTH]),
		.q_tag        (sccc_tag_t'(q_data[TAG_WIDTH-1:0])),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_collision(collision)
	);

endmodule

`default_nettype wire
